### design/tssg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triangle scanline span generator.
// No dependencies; imported by tssg_ctrl, tssg_datapath, the top level and the bench.
package tssg_pkg;

  localparam int unsigned CANVAS_BITS = 13;
  localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 13'd1600;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_NEXT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_OUT,
    ST_NONE_OUT,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_SPAN_OUT
  } tssg_state_e;

  typedef enum logic [1:0] {
    RES_LOAD,
    RES_NONE,
    RES_SPAN
  } tssg_res_e;

  typedef struct packed {
    logic      load;       // commit sorted vertices and reset the row counter
    logic      calc;       // register edge products and divisors
    logic      start_div;  // launch both dividers
    logic      emit;       // write the output register
    tssg_res_e res_sel;
  } tssg_cmd_t;

  typedef struct packed {
    logic active;    // rows remain for the loaded triangle
    logic div_busy;
    logic out_free;  // output register can take a beat this cycle
  } tssg_sts_t;

endpackage

### design/tssg_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing; used twice by tssg_datapath.
module tssg_div #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [2*COORD_BITS-1:0]   num_i,
  input  logic [COORD_BITS-1:0]     den_i,
  output logic                      busy_o,
  output logic [COORD_BITS-1:0]     quo_o
);

  localparam int unsigned CNT_W = $clog2(COORD_BITS);

  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] shq_q, shq_d;
  logic [COORD_BITS-1:0] den_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [COORD_BITS:0]   trial;
  logic                  ge;

  // The quotient is known to fit in COORD_BITS, so the upper half of the
  // numerator starts out below the divisor and only the lower half shifts in.
  always_comb begin
    trial  = {rem_q, shq_q[COORD_BITS-1]};
    ge     = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    shq_d  = shq_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = num_i[2*COORD_BITS-1:COORD_BITS];
      shq_d  = num_i[COORD_BITS-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? COORD_BITS'(trial - {1'b0, den_q}) : trial[COORD_BITS-1:0];
      shq_d = {shq_q[COORD_BITS-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(COORD_BITS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shq_q <= shq_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = shq_q;

endmodule

### design/tssg_datapath.sv
`timescale 1ns / 1ps
// Datapath: vertex sort, triangle state, edge products, two dividers,
// span assembly and the output register. Depends on tssg_pkg and tssg_div.
module tssg_datapath #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tssg_pkg::tssg_cmd_t                cmd_i,
  output tssg_pkg::tssg_sts_t                sts_o,
  input  logic                               cfg_we_i,
  input  logic [tssg_pkg::CANVAS_BITS-1:0]   cfg_wdata_i,
  input  logic [COORD_BITS-1:0]              vertex_a_x_i,
  input  logic [COORD_BITS-1:0]              vertex_a_y_i,
  input  logic [COORD_BITS-1:0]              vertex_b_x_i,
  input  logic [COORD_BITS-1:0]              vertex_b_y_i,
  input  logic [COORD_BITS-1:0]              vertex_c_x_i,
  input  logic [COORD_BITS-1:0]              vertex_c_y_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic                               span_valid_o,
  output logic [COORD_BITS-1:0]              row_o,
  output logic [COORD_BITS-1:0]              start_x_o,
  output logic [COORD_BITS-1:0]              end_x_o,
  output logic                               last_o
);
  import tssg_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned PW   = 2 * CB;
  localparam int unsigned CMPW = (CB > CANVAS_BITS) ? CB : CANVAS_BITS;

  // triangle state
  logic [CB-1:0] tx_q, ty_q, mx_q, my_q, bx_q, by_q;
  logic [CB-1:0] row_q, row_d;
  logic          active_q, active_d;
  logic [CANVAS_BITS-1:0] canvas_q;

  // sort network
  logic [CB-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tmp_x, tmp_y;

  // product stage
  logic [CB-1:0] al, bl, as, bs, ds;
  logic          sgl, sgs;
  logic [PW-1:0] pl_q, ps_q;
  logic [CB-1:0] dl_q, ds_q;
  logic          sgl_q, sgs_q;

  // divider results and span assembly
  logic          busy_l, busy_s;
  logic [CB-1:0] ql, qs, xl, xs, lo_x, hi_x, end_x;
  logic [CB:0]   row_inc;
  logic          last_row;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          out_free;
  logic          span_valid_d, last_d;
  logic [CB-1:0] row_out_d, start_d, end_d;
  logic          span_valid_q, last_q;
  logic [CB-1:0] row_out_q, start_q, end_q;

  // Three compare-swaps on y: (b,c), (a,b), (b,c); swap only on strictly greater.
  always_comb begin
    sx0 = vertex_a_x_i; sy0 = vertex_a_y_i;
    sx1 = vertex_b_x_i; sy1 = vertex_b_y_i;
    sx2 = vertex_c_x_i; sy2 = vertex_c_y_i;
    tmp_x = '0;
    tmp_y = '0;
    if (sy1 > sy2) begin
      tmp_x = sx1; tmp_y = sy1; sx1 = sx2; sy1 = sy2; sx2 = tmp_x; sy2 = tmp_y;
    end
    if (sy0 > sy1) begin
      tmp_x = sx0; tmp_y = sy0; sx0 = sx1; sy0 = sy1; sx1 = tmp_x; sy1 = tmp_y;
    end
    if (sy1 > sy2) begin
      tmp_x = sx1; tmp_y = sy1; sx1 = sx2; sy1 = sy2; sx2 = tmp_x; sy2 = tmp_y;
    end
  end

  // Edge terms as magnitude and sign, so the divide is unsigned and truncation
  // toward zero falls out of applying the sign afterwards.
  always_comb begin
    al  = (bx_q >= tx_q) ? bx_q - tx_q : tx_q - bx_q;
    sgl = bx_q < tx_q;
    bl  = row_q - ty_q;
    if (row_q < my_q) begin
      as  = (tx_q >= mx_q) ? tx_q - mx_q : mx_q - tx_q;
      sgs = tx_q < mx_q;
      bs  = my_q - row_q;
      ds  = my_q - ty_q;
    end else begin
      as  = (bx_q >= mx_q) ? bx_q - mx_q : mx_q - bx_q;
      sgs = bx_q < mx_q;
      bs  = row_q - my_q;
      ds  = by_q - my_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      pl_q  <= PW'(al) * PW'(bl);
      ps_q  <= PW'(as) * PW'(bs);
      dl_q  <= by_q - ty_q;
      ds_q  <= ds;
      sgl_q <= sgl;
      sgs_q <= sgs;
    end
  end

  tssg_div #(.COORD_BITS(CB)) u_div_long (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_div),
    .num_i   (pl_q),
    .den_i   (dl_q),
    .busy_o  (busy_l),
    .quo_o   (ql)
  );

  tssg_div #(.COORD_BITS(CB)) u_div_short (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_div),
    .num_i   (ps_q),
    .den_i   (ds_q),
    .busy_o  (busy_s),
    .quo_o   (qs)
  );

  // Both edge x values lie between their end points, so no bits are lost here.
  always_comb begin
    xl       = sgl_q ? tx_q - ql : tx_q + ql;
    xs       = sgs_q ? mx_q - qs : mx_q + qs;
    lo_x     = (xl > xs) ? xs : xl;
    hi_x     = (xl > xs) ? xl : xs;
    end_x    = (CMPW'(hi_x) > CMPW'(canvas_q)) ? CB'(canvas_q) : hi_x;
    row_inc  = {1'b0, row_q} + 1'b1;
    last_row = row_inc >= {1'b0, by_q};
  end

  // Result selection and state update
  always_comb begin
    row_d        = row_q;
    active_d     = active_q;
    span_valid_d = 1'b0;
    row_out_d    = '0;
    start_d      = '0;
    end_d        = '0;
    last_d       = 1'b1;
    if (cmd_i.load) begin
      row_d    = sy0;
      active_d = sy0 < sy2;
    end
    case (cmd_i.res_sel)
      RES_LOAD: begin
        last_d = !active_q;
      end
      RES_NONE: begin
        last_d = 1'b1;
      end
      RES_SPAN: begin
        span_valid_d = 1'b1;
        row_out_d    = row_q;
        start_d      = lo_x;
        end_d        = end_x;
        last_d       = last_row;
        if (cmd_i.emit) begin
          row_d = row_inc[CB-1:0];
          if (last_row) begin
            active_d = 1'b0;
          end
        end
      end
      default: begin
        last_d = 1'b1;
      end
    endcase
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      active_q    <= 1'b0;
      canvas_q    <= CANVAS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        canvas_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_q <= sx0; ty_q <= sy0;
      mx_q <= sx1; my_q <= sy1;
      bx_q <= sx2; by_q <= sy2;
    end
    if (cmd_i.emit) begin
      span_valid_q <= span_valid_d;
      row_out_q    <= row_out_d;
      start_q      <= start_d;
      end_q        <= end_d;
      last_q       <= last_d;
    end
  end

  assign sts_o.active   = active_q;
  assign sts_o.div_busy = busy_l || busy_s;
  assign sts_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign span_valid_o = span_valid_q;
  assign row_o        = row_out_q;
  assign start_x_o    = start_q;
  assign end_x_o      = end_q;
  assign last_o       = last_q;

endmodule

### design/tssg_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: input handshake and sequencing of the datapath.
// Depends on tssg_pkg.
module tssg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                req_type_i,
  output logic                in_stall_o,
  input  tssg_pkg::tssg_sts_t sts_i,
  output tssg_pkg::tssg_cmd_t cmd_o
);
  import tssg_pkg::*;

  tssg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    cmd_o.load      = 1'b0;
    cmd_o.calc      = 1'b0;
    cmd_o.start_div = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.res_sel   = RES_NONE;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (req_type_i == REQ_LOAD) begin
            cmd_o.load = 1'b1;
            state_d    = ST_LOAD_OUT;
          end else if (sts_i.active) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_NONE_OUT;
          end
        end
      end
      ST_LOAD_OUT: begin
        cmd_o.res_sel = RES_LOAD;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_NONE_OUT: begin
        cmd_o.res_sel = RES_NONE;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_START;
      end
      ST_START: begin
        cmd_o.start_div = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_SPAN_OUT;
        end
      end
      ST_SPAN_OUT: begin
        cmd_o.res_sel = RES_SPAN;
        // hold the finished span until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/triangle_scanline_span_generator.sv
`timescale 1ns / 1ps
// Triangle scanline span generator. A load or empty request is accepted, then
// its beat is written to the output register once that is free; a span request
// first runs the edge products, the divider start and the two bit-serial edge
// dividers side by side. One request at a time, taken the cycle after the
// result is written; an output stall holds the next request off. Async reset
// clears control state, row counter and triangle flag; canvas 1600.
module triangle_scanline_span_generator #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tssg_pkg::CANVAS_BITS-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [COORD_BITS-1:0]            vertex_a_x_i,
  input  logic [COORD_BITS-1:0]            vertex_a_y_i,
  input  logic [COORD_BITS-1:0]            vertex_b_x_i,
  input  logic [COORD_BITS-1:0]            vertex_b_y_i,
  input  logic [COORD_BITS-1:0]            vertex_c_x_i,
  input  logic [COORD_BITS-1:0]            vertex_c_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             span_valid_o,
  output logic [COORD_BITS-1:0]            row_o,
  output logic [COORD_BITS-1:0]            start_x_o,
  output logic [COORD_BITS-1:0]            end_x_o,
  output logic                             last_o
);
  import tssg_pkg::*;

  tssg_cmd_t cmd;
  tssg_sts_t sts;

  tssg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tssg_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .vertex_a_x_i (vertex_a_x_i),
    .vertex_a_y_i (vertex_a_y_i),
    .vertex_b_x_i (vertex_b_x_i),
    .vertex_b_y_i (vertex_b_y_i),
    .vertex_c_x_i (vertex_c_x_i),
    .vertex_c_y_i (vertex_c_y_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .span_valid_o (span_valid_o),
    .row_o        (row_o),
    .start_x_o    (start_x_o),
    .end_x_o      (end_x_o),
    .last_o       (last_o)
  );

endmodule

### design/tssg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the span generator and its bind to the top level.
// Depends on triangle_scanline_span_generator.
module tssg_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  span_valid_o,
  input logic [COORD_BITS-1:0] row_o,
  input logic [COORD_BITS-1:0] start_x_o,
  input logic [COORD_BITS-1:0] end_x_o,
  input logic                  last_o
);

  // a stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(row_o) && $stable(start_x_o)
                                   && $stable(end_x_o) && $stable(last_o))
    else $error("stalled result payload changed");

  // one request at a time: an accepted beat closes the input in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on consecutive cycles");

  // a result without a span carries no coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !span_valid_o |-> row_o == '0 && start_x_o == '0 && end_x_o == '0)
    else $error("non-span result with nonzero fields");

endmodule

bind triangle_scanline_span_generator tssg_checker #(.COORD_BITS(COORD_BITS)) u_tssg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .span_valid_o (span_valid_o),
  .row_o        (row_o),
  .start_x_o    (start_x_o),
  .end_x_o      (end_x_o),
  .last_o       (last_o)
);

### sim/triangle_scanline_span_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for triangle_scanline_span_generator: predicts every span beat
// from the loaded vertices, the row counter and the canvas width, and checks in order.
// Depends on tssg_pkg and the RTL top level only.
module triangle_scanline_span_generator_tb;
  import tssg_pkg::*;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned CMAX        = (1 << COORD_BITS) - 1;
  localparam int unsigned QUIET_LO    = 600;
  localparam int unsigned QUIET_HI    = 760;
  localparam int unsigned HOLD_AT     = 260;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned PHASE_ITEMS = 165;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   span_valid;
    coord_t row;
    coord_t start_x;
    coord_t end_x;
    logic   last;
  } span_beat_t;

  typedef struct packed {
    logic   req_type;
    coord_t ax, ay, bx, by, cx, cy;
  } tri_req_t;

  class span_scoreboard;
    logic [CANVAS_BITS-1:0] canvas;
    longint      vtx[6];  // top x/y, middle x/y, bottom x/y
    longint      cur_row;
    bit          active;
    span_beat_t  expected_spans[$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned loads_seen;
    int unsigned spans_seen;

    function new();
      canvas = CANVAS_RESET;
      foreach (vtx[i]) vtx[i] = 0;
      cur_row = 0;
      active = 1'b0;
      mismatches = 0;
      beats_checked = 0;
      loads_seen = 0;
      spans_seen = 0;
    endfunction

    function void set_canvas(logic [CANVAS_BITS-1:0] w);
      canvas = w;
    endfunction

    function void swap_vtx(int p, int q);
      longint tx, ty;
      tx = vtx[2*p];
      ty = vtx[2*p+1];
      vtx[2*p] = vtx[2*q];
      vtx[2*p+1] = vtx[2*q+1];
      vtx[2*q] = tx;
      vtx[2*q+1] = ty;
    endfunction

    // Signed 64-bit division truncates toward zero, as the block must.
    function longint edge_at(longint vx, longint vy, longint dx, longint dy, longint y);
      return vx + (dx * (y - vy)) / dy;
    endfunction

    function void note_request(tri_req_t r);
      span_beat_t b;
      longint y, sx, ex, t;
      b = '0;
      if (r.req_type == REQ_LOAD) begin
        vtx[0] = r.ax; vtx[1] = r.ay;
        vtx[2] = r.bx; vtx[3] = r.by;
        vtx[4] = r.cx; vtx[5] = r.cy;
        if (vtx[3] > vtx[5]) swap_vtx(1, 2);
        if (vtx[1] > vtx[3]) swap_vtx(0, 1);
        if (vtx[3] > vtx[5]) swap_vtx(1, 2);
        cur_row = vtx[1];
        active = vtx[1] < vtx[5];
        b.last = !active;
        loads_seen++;
      end else if (!active) begin
        b.last = 1'b1;
      end else begin
        y = cur_row;
        sx = edge_at(vtx[0], vtx[1], vtx[0] - vtx[4], vtx[1] - vtx[5], y);
        if (y < vtx[3])
          ex = edge_at(vtx[2], vtx[3], vtx[0] - vtx[2], vtx[1] - vtx[3], y);
        else
          ex = edge_at(vtx[2], vtx[3], vtx[2] - vtx[4], vtx[3] - vtx[5], y);
        if (sx > ex) begin
          t = sx;
          sx = ex;
          ex = t;
        end
        if (ex > longint'(canvas)) ex = longint'(canvas);
        b.span_valid = 1'b1;
        b.row = coord_t'(y);
        b.start_x = coord_t'(sx);
        b.end_x = coord_t'(ex);
        cur_row = (y + 1) & CMAX;
        if (y + 1 >= vtx[5]) begin
          active = 1'b0;
          b.last = 1'b1;
        end
        spans_seen++;
      end
      expected_spans.push_back(b);
    endfunction

    function void report(string what, span_beat_t want, span_beat_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t %s: expected valid=%0b row=%0d start=%0d end=%0d last=%0b,",
                  " got valid=%0b row=%0d start=%0d end=%0d last=%0b"},
                 $time, what, want.span_valid, want.row, want.start_x, want.end_x,
                 want.last, got.span_valid, got.row, got.start_x, got.end_x, got.last);
    endfunction

    function void check_result(span_beat_t got);
      span_beat_t want;
      if (expected_spans.size() == 0) begin
        report("beat with nothing expected", '0, got);
        return;
      end
      want = expected_spans.pop_front();
      beats_checked++;
      if (got.span_valid !== want.span_valid || got.row !== want.row ||
          got.start_x !== want.start_x || got.end_x !== want.end_x ||
          got.last !== want.last)
        report("span mismatch", want, got);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CANVAS_BITS-1:0] cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   req_type_i;
  coord_t                 vertex_a_x_i, vertex_a_y_i;
  coord_t                 vertex_b_x_i, vertex_b_y_i;
  coord_t                 vertex_c_x_i, vertex_c_y_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   span_valid_o;
  coord_t                 row_o, start_x_o, end_x_o;
  logic                   last_o;

  span_scoreboard sb;
  int unsigned    items_sent = 0;
  int unsigned    widths_used = 0;

  always #4 clk = ~clk;

  triangle_scanline_span_generator #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .vertex_a_x_i(vertex_a_x_i),
    .vertex_a_y_i(vertex_a_y_i),
    .vertex_b_x_i(vertex_b_x_i),
    .vertex_b_y_i(vertex_b_y_i),
    .vertex_c_x_i(vertex_c_x_i),
    .vertex_c_y_i(vertex_c_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .span_valid_o(span_valid_o),
    .row_o       (row_o),
    .start_x_o   (start_x_o),
    .end_x_o     (end_x_o),
    .last_o      (last_o)
  );

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return coord_t'(CMAX);
      default: return coord_t'($urandom_range(0, CMAX));
    endcase
  endfunction

  function automatic tri_req_t random_payload();
    tri_req_t r;
    r.req_type = REQ_NEXT;
    r.ax = rand_coord(); r.ay = rand_coord();
    r.bx = rand_coord(); r.by = rand_coord();
    r.cx = rand_coord(); r.cy = rand_coord();
    return r;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the beat.
  task automatic send_item(tri_req_t r);
    while (!(items_sent >= QUIET_LO && items_sent < QUIET_HI) && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    req_type_i   <= r.req_type;
    vertex_a_x_i <= r.ax; vertex_a_y_i <= r.ay;
    vertex_b_x_i <= r.bx; vertex_b_y_i <= r.by;
    vertex_c_x_i <= r.cx; vertex_c_y_i <= r.cy;
    in_valid_i   <= 1'b1;
    do @(posedge clk); while (!(in_valid_i && !in_stall_o));
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic load_tri(int ax, int ay, int bx, int by, int cx, int cy);
    tri_req_t r;
    r.req_type = REQ_LOAD;
    r.ax = coord_t'(ax); r.ay = coord_t'(ay);
    r.bx = coord_t'(bx); r.by = coord_t'(by);
    r.cx = coord_t'(cx); r.cy = coord_t'(cy);
    send_item(r);
  endtask

  task automatic next_rows(int unsigned n);
    repeat (n) send_item(random_payload());
  endtask

  // Hold the input off until every predicted beat has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.expected_spans.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_canvas(logic [CANVAS_BITS-1:0] w);
    cfg_wdata_i <= w;
    cfg_we_i    <= 1'b1;
    @(posedge clk);
    cfg_we_i    <= 1'b0;
    sb.set_canvas(w);
    widths_used++;
  endtask

  task automatic run_directed();
    next_rows(1);                                       // no triangle yet
    load_tri(0, 0, 0, 0, 0, 0);                         // degenerate, no rows
    next_rows(1);
    load_tri(CMAX, CMAX, 0, CMAX - 2, 2048, CMAX - 1);  // bottom of the y range
    next_rows(3);                                       // last row, then one past it
    load_tri(0, 10, CMAX, 10, 2000, 13);                // flat top
    next_rows(3);
    load_tri(3000, 23, 100, 20, CMAX, 23);              // flat bottom
    next_rows(3);
    load_tri(10, 0, 20, 5, 0, 9);                       // cut short by the next load
    next_rows(2);
    load_tri(5, 100, 4000, 100, 9, 100);                // all on one row
    next_rows(1);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned goal, kind, h, base, k, j;
    coord_t      ys[3];
    coord_t      t;
    tri_req_t    r;
    goal = items_sent + n;
    while (items_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        h = ($urandom_range(9) == 0) ? $urandom_range(16, 60) : $urandom_range(0, 12);
        base = $urandom_range(0, CMAX - h);
        ys[0] = coord_t'(base);
        ys[1] = coord_t'(base + h);
        ys[2] = coord_t'($urandom_range(base, base + h));
        for (k = 2; k > 0; k--) begin
          j = $urandom_range(k);
          t = ys[k];
          ys[k] = ys[j];
          ys[j] = t;
        end
        r = random_payload();
        r.req_type = REQ_LOAD;
        r.ay = ys[0]; r.by = ys[1]; r.cy = ys[2];
        send_item(r);
        if (kind < 60)
          next_rows(h + (($urandom_range(9) < 3) ? $urandom_range(1, 2) : 0));
        else
          next_rows($urandom_range(0, h));
      end else if (kind < 85) begin
        r = random_payload();
        r.req_type = REQ_LOAD;
        send_item(r);
        next_rows($urandom_range(0, 6));
      end else begin
        next_rows($urandom_range(1, 3));
      end
    end
  endtask

  // Result side: check each accepted beat, drive stall, one long hold-off.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned beats;
    bit          hold_done;
    span_beat_t  got;
    hold_left = 0;
    beats = 0;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.span_valid = span_valid_o;
        got.row = row_o;
        got.start_x = start_x_o;
        got.end_x = end_x_o;
        got.last = last_o;
        sb.check_result(got);
        beats++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && beats >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (beats >= QUIET_LO && beats < QUIET_HI) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 36);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_flow
    logic [CANVAS_BITS-1:0] widths[6];
    int unsigned            failures;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_LOAD;
    vertex_a_x_i = '0; vertex_a_y_i = '0;
    vertex_b_x_i = '0; vertex_b_y_i = '0;
    vertex_c_x_i = '0; vertex_c_y_i = '0;
    sb = new();
    widths[0] = 13'd4096;
    widths[1] = 13'd1;
    widths[2] = 13'd4095;
    widths[3] = 13'd0;
    widths[4] = CANVAS_BITS'($urandom_range(1, 4096));
    widths[5] = CANVAS_RESET;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_for_results();
    foreach (widths[i]) begin
      write_canvas(widths[i]);
      run_random(PHASE_ITEMS);
      wait_for_results();
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    failures = sb.mismatches + sb.expected_spans.size();
    $display("Sent %0d requests (%0d triangle loads); checked %0d beats, %0d of them spans.",
             items_sent, sb.loads_seen, sb.beats_checked, sb.spans_seen);
    $display("Canvas widths written: %0d, down to zero; one long output hold-off applied.",
             widths_used);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### triangle_scanline_span_generator.f
design/tssg_pkg.sv
design/tssg_div.sv
design/tssg_datapath.sv
design/tssg_ctrl.sv
design/triangle_scanline_span_generator.sv
design/tssg_checker.sv
sim/triangle_scanline_span_generator_tb.sv
